// ===== rtl/core/top_k_score_select_unit_macros.svh =====
// Assertion macros for the top-k score selection unit.
// Depends on clk_i and rst_ni in the module that uses them.
`ifndef TOP_K_SCORE_SELECT_UNIT_MACROS_SVH
`define TOP_K_SCORE_SELECT_UNIT_MACROS_SVH

// same-cycle implication
`define TKSEL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TKSEL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tksel_pkg.sv =====
// Shared widths, constants and types for the top-k score selection unit.
// No dependencies.
package tksel_pkg;

  localparam int unsigned SCORE_W       = 32;
  localparam int unsigned INDEX_W       = 16;
  localparam int unsigned KSEL_W        = 6;
  localparam int unsigned K_MAX_DEF     = 32;
  localparam int unsigned MAX_CENTROIDS = 65536;
  localparam int unsigned IDX_WRAP      = (MAX_CENTROIDS < 65536) ? MAX_CENTROIDS : 65536;
  localparam logic [KSEL_W-1:0] KSEL_RESET = KSEL_W'(8);

  typedef struct packed {
    logic                      valid;
    logic signed [SCORE_W-1:0] score;
    logic [INDEX_W-1:0]        index;
  } tksel_entry_t;

  typedef struct packed {
    logic step;  // score beat accepted: sorted insert
    logic pop;   // head moves to output, chain shifts up
  } tksel_ctrl_t;

endpackage

// ===== rtl/core/tksel_cell.sv =====
// One slot of the sorted top-k chain: holds a score, its index and a valid bit.
// Depends on tksel_pkg.
module tksel_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tksel_pkg::tksel_ctrl_t  ctrl_i,
  input  logic                  in_range_i,
  input  tksel_pkg::tksel_entry_t new_i,
  input  tksel_pkg::tksel_entry_t prev_i,
  input  logic                  prev_gt_i,
  input  tksel_pkg::tksel_entry_t next_i,
  output tksel_pkg::tksel_entry_t entry_o,
  output logic                  gt_o
);
  import tksel_pkg::*;

  logic                valid_q;
  logic [SCORE_W-1:0]  score_q;
  logic [INDEX_W-1:0]  index_q;
  tksel_entry_t        entry_d;

  assign entry_o.valid = valid_q;
  assign entry_o.score = score_q;
  assign entry_o.index = index_q;

  // new score belongs at or above this slot
  assign gt_o = !valid_q || (new_i.score > entry_o.score);

  always_comb begin
    entry_d = entry_o;
    if (ctrl_i.step) begin
      if (!in_range_i) begin
        entry_d.valid = 1'b0;
      end else if (prev_gt_i) begin
        entry_d = prev_i;
      end else if (gt_o) begin
        entry_d = new_i;
      end
    end else if (ctrl_i.pop) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= entry_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= entry_d.score;
    index_q <= entry_d.index;
  end

endmodule

// ===== rtl/core/top_k_score_select_unit.sv =====
// Top-k score selection: one score beat per cycle except while draining, sorted insert
// into a cell chain. At the token's last beat the kept entries drain in descending order,
// one per cycle when out_stall_i is low; the first result passes through drain_q and then
// the output register, and the next token is taken after the final pop.
// Reset clears cell valid bits, the index counter and sets k_select to 8; no clearing pass.
// Depends on tksel_pkg, tksel_cell and top_k_score_select_unit_macros.svh.
`include "top_k_score_select_unit_macros.svh"

module top_k_score_select_unit #(
  parameter int unsigned K_MAX = tksel_pkg::K_MAX_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tksel_pkg::KSEL_W-1:0]         cfg_k_select_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [tksel_pkg::SCORE_W-1:0] score_in_i,
  input  logic                                 last_of_token_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [tksel_pkg::SCORE_W-1:0] score_out_o,
  output logic [tksel_pkg::INDEX_W-1:0]        centroid_index_o,
  output logic                                 last_result_o
);
  import tksel_pkg::*;

  logic [KSEL_W-1:0]  k_select_q;
  logic [INDEX_W-1:0] next_index_q, next_index_d;
  logic               drain_q, drain_d;
  logic               out_valid_q, out_valid_d;
  logic [SCORE_W-1:0] out_score_q, out_score_d;
  logic [INDEX_W-1:0] out_index_q, out_index_d;
  logic               out_last_q, out_last_d;

  tksel_ctrl_t        ctrl;
  tksel_entry_t       new_entry;
  tksel_entry_t       cell_q [K_MAX];
  logic [K_MAX-1:0]   gt;
  logic [K_MAX-1:0]   vld;
  logic [K_MAX-1:0]   in_range;
  logic [K_MAX:0]     vld_ext;
  logic               in_acc;
  logic               pop_last;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = drain_q;
  assign in_acc      = in_valid_i && !drain_q;

  assign ctrl.step = in_acc;
  assign ctrl.pop  = drain_q && (!out_valid_q || !out_stall_i);

  assign new_entry.valid = 1'b1;
  assign new_entry.score = score_in_i;
  assign new_entry.index = next_index_q;

  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    tksel_entry_t prev_e, next_e;
    logic         prev_gt;

    assign in_range[i] = (i == 0) || (KSEL_W'(i) < k_select_q);
    assign vld[i]      = cell_q[i].valid;

    if (i == 0) begin : g_head
      assign prev_e  = '0;
      assign prev_gt = 1'b0;
    end else begin : g_body
      assign prev_e  = cell_q[i-1];
      assign prev_gt = gt[i-1];
    end

    if (i == K_MAX - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = cell_q[i+1];
    end

    tksel_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .in_range_i (in_range[i]),
      .new_i      (new_entry),
      .prev_i     (prev_e),
      .prev_gt_i  (prev_gt),
      .next_i     (next_e),
      .entry_o    (cell_q[i]),
      .gt_o       (gt[i])
    );
  end

  assign vld_ext  = {1'b0, vld};
  assign pop_last = !vld_ext[1];

  always_comb begin
    next_index_d = next_index_q;
    drain_d      = drain_q;
    out_valid_d  = out_valid_q;
    out_score_d  = out_score_q;
    out_index_d  = out_index_q;
    out_last_d   = out_last_q;

    if (in_acc) begin
      if (last_of_token_i) begin
        next_index_d = '0;
        drain_d      = 1'b1;
      end else if (next_index_q == INDEX_W'(IDX_WRAP - 1)) begin
        next_index_d = '0;
      end else begin
        next_index_d = next_index_q + INDEX_W'(1);
      end
    end

    if (ctrl.pop) begin
      out_valid_d = 1'b1;
      out_score_d = cell_q[0].score;
      out_index_d = cell_q[0].index;
      out_last_d  = pop_last;
      if (pop_last) begin
        drain_d = 1'b0;
      end
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_select_q   <= KSEL_RESET;
      next_index_q <= '0;
      drain_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        k_select_q <= cfg_k_select_i;
      end
      next_index_q <= next_index_d;
      drain_q      <= drain_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_score_q <= out_score_d;
    out_index_q <= out_index_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign score_out_o      = out_score_q;
  assign centroid_index_o = out_index_q;
  assign last_result_o    = out_last_q;

  `TKSEL_ASSERT_NXT(a_last_beat_drains, in_acc && last_of_token_i, in_stall_o, "no drain")
  `TKSEL_ASSERT_IMP(a_valid_prefix, 1'b1, ((vld >> 1) & ~vld) == '0, "valid bits not a prefix")
  `TKSEL_ASSERT_NXT(a_last_pop_ends_drain, ctrl.pop && pop_last, !drain_q, "drain past final pop")

endmodule

// ===== tb/top_k_score_select_checker.sv =====
`timescale 1ns / 100ps
// Checker for top_k_score_select_unit: watches the config, score and result channels,
// keeps its own sorted top-k list per token and compares every result beat in order.
// Depends on tksel_pkg.
module top_k_score_select_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [tksel_pkg::KSEL_W-1:0]         cfg_k_select_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic signed [tksel_pkg::SCORE_W-1:0] score_in_i,
  input  logic                                 last_of_token_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic signed [tksel_pkg::SCORE_W-1:0] score_out_i,
  input  logic [tksel_pkg::INDEX_W-1:0]        centroid_index_i,
  input  logic                                 last_result_i,
  output int unsigned                          fail_count_o,
  output int unsigned                          pending_o,
  output int unsigned                          checked_o
);
  import tksel_pkg::*;

  localparam int unsigned KEEP_MAX = K_MAX_DEF;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [INDEX_W-1:0]        index;
    logic                      last;
  } pick_t;

  logic signed [SCORE_W-1:0] kept_score [KEEP_MAX];
  logic [INDEX_W-1:0]        kept_index [KEEP_MAX];
  int unsigned               kept_n;
  int unsigned               next_idx;
  logic [KSEL_W-1:0]         k_reg;
  pick_t                     token_picks [$];
  int unsigned               fails;
  int unsigned               checked;

  task insert_score(input logic signed [SCORE_W-1:0] s, input logic last);
    int unsigned    k;
    int unsigned    pos;
    int unsigned    i;
    logic [INDEX_W-1:0] idx;
    pick_t          p;
    k = k_reg;
    if (k < 1) k = 1;
    if (k > KEEP_MAX) k = KEEP_MAX;
    idx = INDEX_W'(next_idx);
    if (kept_n > k) kept_n = k;
    pos = KEEP_MAX;
    if (kept_n < k) begin
      pos = kept_n;
      kept_n++;
    end else if (s > kept_score[kept_n-1]) begin
      pos = kept_n - 1;
    end
    if (pos < KEEP_MAX) begin
      // equal scores stay behind earlier arrivals
      while (pos > 0 && kept_score[pos-1] < s) begin
        kept_score[pos] = kept_score[pos-1];
        kept_index[pos] = kept_index[pos-1];
        pos--;
      end
      kept_score[pos] = s;
      kept_index[pos] = idx;
    end
    next_idx++;
    if (next_idx >= IDX_WRAP) next_idx = 0;
    if (last) begin
      for (i = 0; i < kept_n; i++) begin
        p.score = kept_score[i];
        p.index = kept_index[i];
        p.last  = (i + 1 == kept_n);
        token_picks.insert(token_picks.size(), p);
      end
      kept_n   = 0;
      next_idx = 0;
    end
  endtask

  task check_pick();
    pick_t p;
    if (token_picks.size() == 0) begin
      $error("result beat with nothing pending: score_out %0d centroid_index %0d",
             score_out_i, centroid_index_i);
      fails++;
    end else begin
      p = token_picks.pop_front();
      if (score_out_i !== p.score) begin
        $error("score_out: expected %0d, got %0d", p.score, score_out_i);
        fails++;
      end
      if (centroid_index_i !== p.index) begin
        $error("centroid_index: expected %0d, got %0d", p.index, centroid_index_i);
        fails++;
      end
      if (last_result_i !== p.last) begin
        $error("last_result: expected %0b, got %0b", p.last, last_result_i);
        fails++;
      end
      checked++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_n   = 0;
      next_idx = 0;
      k_reg    = KSEL_RESET;
      token_picks.delete();
      fails    = 0;
      checked  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_pick();
      if (in_valid_i && !in_stall_i) insert_score(score_in_i, last_of_token_i);
      if (cfg_valid_i && cfg_ready_i) k_reg = cfg_k_select_i;
    end
    fail_count_o <= fails;
    pending_o    <= token_picks.size();
    checked_o    <= checked;
  end

endmodule

// ===== tb/top_k_score_select_unit_test.sv =====
`timescale 1ns / 100ps
// Testbench top for top_k_score_select_unit: drives config writes, score tokens and
// result stalls, and gives the verdict from the checker's failure count.
// Depends on tksel_pkg, top_k_score_select_unit and top_k_score_select_checker.
module top_k_score_select_unit_test;
  import tksel_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_BEATS = 420;

  typedef enum logic [1:0] {SC_WIDE, SC_TIES, SC_EDGE, SC_MIXED} score_mix_e;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [KSEL_W-1:0]         cfg_k;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [SCORE_W-1:0] score_in;
  logic                      last_in;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [SCORE_W-1:0] score_out;
  logic [INDEX_W-1:0]        centroid_index;
  logic                      last_result;
  int unsigned               fail_count;
  int unsigned               pending;
  int unsigned               checked;
  int unsigned               cycles = 0;
  int unsigned               beats = 0;
  int unsigned               tokens = 0;
  int unsigned               k_writes = 0;
  bit                        gaps_on = 1'b1;

  top_k_score_select_unit u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_k_select_i   (cfg_k),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .score_in_i       (score_in),
    .last_of_token_i  (last_in),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .score_out_o      (score_out),
    .centroid_index_o (centroid_index),
    .last_result_o    (last_result)
  );

  top_k_score_select_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_k_select_i   (cfg_k),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .score_in_i       (score_in),
    .last_of_token_i  (last_in),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .score_out_i      (score_out),
    .centroid_index_i (centroid_index),
    .last_result_i    (last_result),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results still pending", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic int unsigned stall_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic int unsigned free_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 90) return $urandom_range(7, 20);
    return $urandom_range(50, 150);
  endfunction

  function automatic logic [KSEL_W-1:0] pick_k();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return KSEL_W'($urandom_range(1, 8));
    if (r < 75) return KSEL_W'($urandom_range(9, 32));
    if (r < 85) return KSEL_W'(32);
    if (r < 92) return KSEL_W'(0);
    return KSEL_W'($urandom_range(33, 63));
  endfunction

  function automatic logic signed [SCORE_W-1:0] pick_score(input score_mix_e mix);
    int t;
    if (mix == SC_MIXED) mix = score_mix_e'($urandom_range(0, 2));
    case (mix)
      SC_TIES: begin
        t = $urandom_range(0, 6);
        return SCORE_W'(t - 3);
      end
      SC_EDGE: begin
        case ($urandom_range(0, 5))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0000_0000;
          3: return 32'shFFFF_FFFF;
          4: return 32'sh0001_0000;
          default: return 32'shFFFF_0000;
        endcase
      end
      default: return SCORE_W'($urandom);
    endcase
  endfunction

  // wait for results to drain, then let in-flight inserts finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_k(input logic [KSEL_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_k     <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_k     <= KSEL_W'($urandom);
    k_writes++;
  endtask

  task automatic send_score(input logic signed [SCORE_W-1:0] s, input logic last);
    int unsigned gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      score_in <= SCORE_W'($urandom);
      last_in  <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    score_in <= s;
    last_in  <= last;
    do @(posedge clk); while (in_stall);
    beats++;
    if (last) tokens++;
  endtask

  task automatic send_token(input int unsigned len, input score_mix_e mix);
    int unsigned i;
    for (i = 0; i < len; i++) send_score(pick_score(mix), i + 1 == len);
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      repeat (free_len()) @(posedge clk);
      out_stall <= 1'b1;
      repeat (stall_len()) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  initial begin
    int unsigned i;
    int unsigned r;
    int unsigned start_beats;
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_k     <= '0;
    in_valid  <= 1'b0;
    score_in  <= '0;
    last_in   <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset k of 8, token shorter than k, score extremes
    send_score(32'sh7FFF_FFFF, 1'b0);
    send_score(32'sh8000_0000, 1'b0);
    send_score(32'sh0000_0000, 1'b1);

    // k = 1: single-beat token, then equal scores dropped
    write_k(KSEL_W'(1));
    send_score(32'sh0000_0004, 1'b1);
    send_score(32'sh0000_0005, 1'b0);
    send_score(32'sh0000_0005, 1'b0);
    send_score(32'sh0000_0005, 1'b1);

    // k = 2: tie at the minimum evicts the later one
    write_k(KSEL_W'(2));
    send_score(32'sh0000_0003, 1'b0);
    send_score(32'sh0000_0003, 1'b0);
    send_score(32'sh0000_0007, 1'b1);

    // k = 0 behaves as 1
    write_k(KSEL_W'(0));
    send_score(32'sh0000_0001, 1'b0);
    send_score(32'sh0000_0002, 1'b1);

    // k = 63 clamps to the list size
    write_k(KSEL_W'(63));
    send_score(32'shFFFF_FFFF, 1'b0);
    send_score(32'shFFFF_0000, 1'b0);
    send_score(32'sh0001_0000, 1'b0);
    send_score(32'sh0000_0001, 1'b1);

    // k lowered mid-token: list cut at the next beat
    write_k(KSEL_W'(4));
    for (i = 1; i <= 6; i++) send_score(SCORE_W'(10 * i), 1'b0);
    write_k(KSEL_W'(2));
    send_score(32'sh0000_0005, 1'b1);

    start_beats = beats;
    while (beats - start_beats < RANDOM_BEATS) begin
      if ($urandom_range(0, 2) == 0) write_k(pick_k());
      gaps_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      send_token(r < 70 ? $urandom_range(1, 12) : (r < 92 ? $urandom_range(13, 40) : 1),
                 score_mix_e'($urandom_range(0, 3)));
    end
    gaps_on = 1'b1;

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Run covered %0d score beats in %0d tokens, %0d k writes, %0d result beats checked.",
             beats, tokens, k_writes, checked);
    $display("k spanned 0, 1, 32, 63 and random values, with ties, extremes and output stalls.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
